FILE: hdl/tcmf_pkg.sv
// ============================================================================
// tcmf_pkg: shared types and constants for the three-channel median filter
// Item layouts and default sizes used by the filter and its sub-blocks.
// ============================================================================
package tcmf_pkg;

    localparam int WINDOW_TAPS_DEF   = 5;
    localparam int CHANNEL_COUNT_DEF = 3;
    // Channels below this number carry temperatures; negative readings are dropped.
    localparam int TEMP_CHANNELS     = 2;
    localparam int SAMPLE_W          = 8;

    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] sample_value;
    } tcmf_in_t;

    typedef struct packed {
        logic [7:0] median_value;
        logic       sample_taken;
    } tcmf_out_t;

endpackage

FILE: hdl/tcmf_mem.sv
// ============================================================================
// tcmf_mem: window store
// One row per channel holding the whole window; one write port, one read
// port with registered read data (old data on a same-address collision).
// ============================================================================
module tcmf_mem
#(
    parameter int DEPTH  = 3,
    parameter int WIDTH  = 40,
    parameter int ADDR_W = 2
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/tcmf_median.sv
// ============================================================================
// tcmf_median: rank-select median of one window
// Rank every tap against all others in parallel and pick the middle rank.
// ============================================================================
module tcmf_median
    import tcmf_pkg::*;
#(
    parameter int TAPS = WINDOW_TAPS_DEF
)
(
    input  logic [TAPS-1:0][SAMPLE_W-1:0] window,
    output logic [SAMPLE_W-1:0]           median
);

    localparam int RANK_W = $clog2(TAPS);
    localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(TAPS / 2);

    logic [TAPS-1:0][RANK_W-1:0] rank;

    // Ties break by tap index, so every tap has a distinct rank.
    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < TAPS; j++)
            begin
                if (j < i)
                begin
                    rank[i] = rank[i] + RANK_W'(window[j] <= window[i]);
                end
                else if (j > i)
                begin
                    rank[i] = rank[i] + RANK_W'(window[j] < window[i]);
                end
            end
        end
    end

    always_comb
    begin
        median = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            if (rank[i] == MID_RANK)
            begin
                median = median | window[i];
            end
        end
    end

endmodule

FILE: hdl/three_channel_median_of_five_filter.sv
// ============================================================================
// three_channel_median_of_five_filter: per-channel sliding median filter
// Keeps a WINDOW_TAPS-deep window per channel and returns the window median.
// ============================================================================
//
// Usage
//   Input channel (sample_item/sample_valid/sample_stall): each item names a
//   channel and carries a raw 16-bit reading. Temperature channels drop
//   negative readings; otherwise the low 8 bits shift into that channel's
//   window. A channel number at or above CHANNEL_COUNT changes nothing and
//   returns a zero median with sample_taken low.
//   Output channel (result_item/result_valid/result_stall): one item per
//   input item, in order, with the median of the updated window.
//
// Timing
//   Three register stages: memory read, read-modify-write of the window row,
//   and the median rank network into the output register. One item per
//   cycle is sustained while no stalled result is held; back-to-back items
//   on the same channel are served from a write-back forwarding register,
//   so the window memory never stalls.
//
// Reset and stalls
//   Reset empties the pipeline and clears one valid bit per window row; a
//   row that was never written reads as all zeros. While result_stall holds
//   a waiting result, the whole pipeline freezes and sample_stall is raised.
// ============================================================================
module three_channel_median_of_five_filter
    import tcmf_pkg::*;
#(
    parameter int WINDOW_TAPS   = WINDOW_TAPS_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,

    input  tcmf_in_t  sample_item,
    input  logic      sample_valid,
    output logic      sample_stall,

    output tcmf_out_t result_item,
    output logic      result_valid,
    input  logic      result_stall
);

    localparam int ADDR_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int ROW_W  = WINDOW_TAPS * SAMPLE_W;

    typedef logic [WINDOW_TAPS-1:0][SAMPLE_W-1:0] window_t;

    // Pipeline advance: move everything unless a held result is stalled.
    logic advance;
    logic accept;

    // Stage 1: item waiting for its window row.
    logic                s1_valid_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic                s1_in_range_reg;
    logic                s1_take_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                rd_row_vld_reg;
    logic [ROW_W-1:0]    rd_data;

    // Write-back forwarding of the row written at the previous advance.
    logic                fwd_valid_reg;
    logic                fwd_valid_next;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    window_t             fwd_row_reg;
    logic                fwd_hit;

    // Stage 2: updated window waiting for the median network.
    logic                s2_valid_reg;
    logic                s2_in_range_reg;
    logic                s2_take_reg;
    window_t             s2_window_reg;

    logic [CHANNEL_COUNT-1:0] row_vld_reg;
    logic [CHANNEL_COUNT-1:0] row_vld_next;

    logic                in_range;
    logic                take;
    logic [ADDR_W-1:0]   in_addr;

    window_t             cur_row;
    window_t             new_row;
    logic                wr_en;
    logic [SAMPLE_W-1:0] median;

    logic                result_valid_reg;
    tcmf_out_t           result_item_reg;

    assign advance      = !result_valid_reg || !result_stall;
    assign accept       = sample_valid && advance;
    assign sample_stall = !advance;

    assign in_range = 32'(sample_item.channel) < CHANNEL_COUNT;
    assign take     = !((32'(sample_item.channel) < TEMP_CHANNELS)
                        && sample_item.sample_value[15]);
    assign in_addr  = ADDR_W'(sample_item.channel);

    // ---------------------------------------------------------------- stage 0
    tcmf_mem
    #(
        .DEPTH  (CHANNEL_COUNT),
        .WIDTH  (ROW_W),
        .ADDR_W (ADDR_W)
    )
    u_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (new_row),
        .rd_en   (accept && in_range),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_range;
            s1_take_reg     <= take;
            s1_sample_reg   <= sample_item.sample_value[SAMPLE_W-1:0];
            rd_row_vld_reg  <= in_range && row_vld_reg[in_addr];
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Take the freshest copy of the row: the write of the previous item wins
    // over the memory read issued in the same cycle.
    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);

    always_comb
    begin
        if (fwd_hit)
        begin
            cur_row = fwd_row_reg;
        end
        else if (rd_row_vld_reg)
        begin
            cur_row = window_t'(rd_data);
        end
        else
        begin
            cur_row = '0;
        end
    end

    // Shift out the oldest tap (index 0), append the new sample on top.
    always_comb
    begin
        new_row = cur_row;
        if (s1_take_reg)
        begin
            for (int i = 0; i < WINDOW_TAPS - 1; i++)
            begin
                new_row[i] = cur_row[i + 1];
            end
            new_row[WINDOW_TAPS-1] = s1_sample_reg;
        end
    end

    assign wr_en          = advance && s1_valid_reg && s1_in_range_reg && s1_take_reg;
    assign fwd_valid_next = s1_valid_reg && s1_in_range_reg && s1_take_reg;

    always_comb
    begin
        row_vld_next = row_vld_reg;
        if (wr_en)
        begin
            row_vld_next[s1_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= '0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            row_vld_reg <= row_vld_next;
            if (advance)
            begin
                fwd_valid_reg <= fwd_valid_next;
                s2_valid_reg  <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_addr_reg    <= s1_addr_reg;
            fwd_row_reg     <= new_row;
            s2_in_range_reg <= s1_in_range_reg;
            s2_take_reg     <= s1_take_reg && s1_in_range_reg;
            s2_window_reg   <= new_row;
        end
    end

    // ---------------------------------------------------------------- stage 2
    tcmf_median
    #(
        .TAPS (WINDOW_TAPS)
    )
    u_median
    (
        .window (s2_window_reg),
        .median (median)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= s2_valid_reg;
        end
    end

    // Out-of-range channels report a zero median.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_item_reg.median_value <= s2_in_range_reg ? median : '0;
            result_item_reg.sample_taken <= s2_take_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    // ---------------------------------------------------------------- checks
    a_fwd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> 32'(fwd_addr_reg) < CHANNEL_COUNT)
        else $error("forwarding register holds an out-of-range row");

    a_write_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> s1_valid_reg && s1_in_range_reg && s1_take_reg && advance)
        else $error("window row written for an item that was not taken");

    a_row_vld_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (row_vld_reg & $past(row_vld_reg)) == $past(row_vld_reg))
        else $error("window row valid bit cleared outside reset");

    a_result_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(s2_valid_reg))
        else $error("result appeared without an item in stage 2");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_stall |=> $stable(s2_window_reg) && $stable(s1_valid_reg))
        else $error("pipeline moved while the output was stalled");

endmodule

FILE: tb/sv/tb.sv
// ============================================================================
// tb: self-checking bench for three_channel_median_of_five_filter
// Drives channel/sample items with random gaps, predicts each channel's window
// median on the side, and checks every result item in order against it.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcmf_pkg::*;

    // Channel numbers; anything at or above CHANNEL_COUNT_DEF is out of range.
    localparam logic [1:0] CH_MOS_TEMP      = 2'd0;
    localparam logic [1:0] CH_BOX_TEMP      = 2'd1;
    localparam logic [1:0] CH_MOTOR_CURRENT = 2'd2;
    localparam logic [1:0] CH_UNUSED        = 2'd3;

    localparam int RANDOM_ITEMS   = 1730;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RUN_LIMIT_NS   = 2_000_000;

    // Raw readings that sit on the edges of sign and byte boundaries.
    localparam logic [15:0] EDGE_VALUES [7] = '{
        16'h0000, 16'h00FF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0100, 16'hFF00
    };

    // ------------------------------------------------------------------------
    // Window tracker: keeps its own copy of every channel's delay line, turns
    // each accepted item into the result it must cause, and checks results.
    // ------------------------------------------------------------------------
    class median_tracker;
        logic [7:0] taps [CHANNEL_COUNT_DEF][WINDOW_TAPS_DEF];
        tcmf_out_t  expected_medians [$];
        int         mismatches;
        int         results_checked;

        function new();
            foreach (taps[c, t])
                taps[c][t] = 8'h00;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function logic [7:0] row_median(int ch);
            logic [7:0] sorted [WINDOW_TAPS_DEF];
            logic [7:0] v;
            int         i;
            int         j;
            for (i = 0; i < WINDOW_TAPS_DEF; i++) begin
                v = taps[ch][i];
                j = i;
                while (j > 0 && sorted[j - 1] > v) begin
                    sorted[j] = sorted[j - 1];
                    j--;
                end
                sorted[j] = v;
            end
            return sorted[WINDOW_TAPS_DEF / 2];
        endfunction

        // Advance the addressed window and queue the result it yields.
        function void take_sample(tcmf_in_t it);
            tcmf_out_t r;
            int        ch;
            int        t;
            ch = it.channel;
            r  = '0;
            if (ch < CHANNEL_COUNT_DEF) begin
                r.sample_taken = !(ch < TEMP_CHANNELS && it.sample_value[15]);
                if (r.sample_taken) begin
                    for (t = 0; t < WINDOW_TAPS_DEF - 1; t++)
                        taps[ch][t] = taps[ch][t + 1];
                    taps[ch][WINDOW_TAPS_DEF - 1] = it.sample_value[7:0];
                end
                r.median_value = row_median(ch);
            end
            expected_medians.push_back(r);
        endfunction

        function void note_mismatch(string what, int exp_v, int got_v);
            if (mismatches < 10)
                $display("%0t ns: result %0d %s: expected %0d, got %0d",
                         $time, results_checked, what, exp_v, got_v);
            mismatches++;
        endfunction

        function void check_median(tcmf_out_t got);
            tcmf_out_t exp_r;
            if (expected_medians.size() == 0) begin
                note_mismatch("with no item outstanding, median", -1, got.median_value);
            end
            else begin
                exp_r = expected_medians.pop_front();
                if (got.median_value !== exp_r.median_value)
                    note_mismatch("median_value", exp_r.median_value, got.median_value);
                if (got.sample_taken !== exp_r.sample_taken)
                    note_mismatch("sample_taken", exp_r.sample_taken, got.sample_taken);
            end
            results_checked++;
        endfunction

        function int pending();
            return expected_medians.size();
        endfunction
    endclass

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    tcmf_in_t  sample_item  = '0;
    logic      sample_valid = 1'b0;
    logic      sample_stall;
    tcmf_out_t result_item;
    logic      result_valid;
    logic      result_stall = 1'b0;

    // Set by the stimulus for whole blocks of items: both sides stop idling.
    logic      no_idle      = 1'b0;

    median_tracker medians = new();

    always #2 clk = ~clk;

    three_channel_median_of_five_filter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_item  (sample_item),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_item  (result_item),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // Watch both handshakes at every edge. Note the accepted item first so a
    // result leaving at the same edge still finds its expectation.
    always @(posedge clk) begin
        if (rst_n) begin
            if (sample_valid && !sample_stall)
                medians.take_sample(sample_item);
            if (result_valid && !result_stall)
                medians.check_median(result_item);
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Offer one item and hold it until accepted. Called at a clock edge and
    // returns at the accepting edge; drop valid only when a gap follows, so
    // back-to-back items keep valid high without a second assignment.
    task automatic send_sample(input logic [1:0] ch, input logic [15:0] raw);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_item.channel      <= ch;
        sample_item.sample_value <= raw;
        sample_valid             <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    // Receiver: random stall runs with free runs between them, no random stalls
    // in no_idle blocks, and twice a long hold-off so the pipeline backs up and
    // raises sample_stall while the sender keeps offering items.
    initial begin : receiver
        int stall_len;
        int free_len;
        int holds_done;
        holds_done = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (holds_done < 2 && medians.results_checked >= (holds_done + 1) * 600) begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else begin
                stall_len = no_idle ? 0 : pick_gap();
                if (stall_len > 0) begin
                    result_stall <= 1'b1;
                    repeat (stall_len) @(posedge clk);
                end
                result_stall <= 1'b0;
                free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 20);
                repeat (free_len) @(posedge clk);
            end
        end
    end

    // Stimulus: reset, a directed pass over the edge cases, random blocks,
    // then drain and report.
    initial begin : stimulus
        int          items_sent;
        int          block_len;
        int          mode;
        int          k;
        logic [1:0]  ch;
        logic [1:0]  burst_ch;
        logic [7:0]  burst_base;
        logic [15:0] raw;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Positive extremes and negatives that the temperature channels drop.
        send_sample(CH_MOS_TEMP, 16'h7FFF);
        send_sample(CH_MOS_TEMP, 16'h00FF);
        send_sample(CH_MOS_TEMP, 16'h8000);
        send_sample(CH_MOS_TEMP, 16'hFFFF);
        send_sample(CH_MOS_TEMP, 16'h0180);
        send_sample(CH_MOS_TEMP, 16'h0001);
        send_sample(CH_BOX_TEMP, 16'h00FF);
        send_sample(CH_BOX_TEMP, 16'hFF80);
        send_sample(CH_BOX_TEMP, 16'h1234);
        send_sample(CH_BOX_TEMP, 16'h7F7F);
        // Current channel stores the low byte of negative readings too.
        send_sample(CH_MOTOR_CURRENT, 16'h8000);
        send_sample(CH_MOTOR_CURRENT, 16'hFFFF);
        send_sample(CH_MOTOR_CURRENT, 16'h80FF);
        send_sample(CH_MOTOR_CURRENT, 16'h0000);
        send_sample(CH_MOTOR_CURRENT, 16'h00C8);
        send_sample(CH_MOTOR_CURRENT, 16'h7FFF);
        send_sample(CH_MOTOR_CURRENT, 16'h0055);
        send_sample(CH_MOTOR_CURRENT, 16'h00AA);
        // Out-of-range channel: no window moves, zero result.
        send_sample(CH_UNUSED, 16'h7FFF);
        send_sample(CH_UNUSED, 16'h8000);
        send_sample(CH_UNUSED, 16'hFFFF);

        // Random blocks. Bursts on one channel with close values exercise
        // ties and forwarding; edge blocks reuse the boundary readings; noise
        // blocks mix in the unused channel and dropped readings.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            block_len  = $urandom_range(1, 40);
            mode       = $urandom_range(0, 9);
            burst_ch   = 2'($urandom_range(0, 2));
            burst_base = 8'($urandom);
            no_idle    <= ($urandom_range(0, 4) == 0);
            for (k = 0; k < block_len && items_sent < RANDOM_ITEMS; k++) begin
                if (mode < 4) begin
                    ch  = 2'($urandom_range(0, 2));
                    raw = 16'($urandom);
                end
                else if (mode < 7) begin
                    ch        = burst_ch;
                    raw[15:8] = 8'($urandom);
                    raw[15]   = ($urandom_range(0, 7) == 0);
                    raw[7:0]  = burst_base + 8'($urandom_range(0, 5));
                end
                else if (mode < 9) begin
                    ch  = 2'($urandom_range(0, 2));
                    raw = EDGE_VALUES[$urandom_range(0, 6)];
                end
                else begin
                    ch  = 2'($urandom_range(0, 3));
                    raw = 16'($urandom);
                end
                if ($urandom_range(0, 24) == 0)
                    ch = CH_UNUSED;
                send_sample(ch, raw);
                items_sent++;
            end
        end

        // Release the input side at the last accepting edge, then drain.
        sample_valid <= 1'b0;
        no_idle      <= 1'b0;
        while (medians.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (medians.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hdl/tcmf_pkg.sv
hdl/tcmf_mem.sv
hdl/tcmf_median.sv
hdl/three_channel_median_of_five_filter.sv
tb/sv/tb.sv
